[rtl/bini_pkg.sv]
`timescale 1ns / 1ps
// types and constants of the binary ini record parser
// depends on nothing; used by binary_ini_record_parser_core, bini_token_checker and tb
package bini_pkg;

	// parse phases
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SECTION = 3'd1,
		PH_ENTRY   = 3'd2,
		PH_VALUE   = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	// token kinds
	localparam logic [2:0] TOK_SECTION = 3'd0;
	localparam logic [2:0] TOK_KEY     = 3'd1;
	localparam logic [2:0] TOK_INTEGER = 3'd2;
	localparam logic [2:0] TOK_FLOAT   = 3'd3;
	localparam logic [2:0] TOK_STRING  = 3'd4;
	localparam logic [2:0] TOK_ERROR   = 3'd5;

	// value type codes
	localparam logic [7:0] VT_INTEGER = 8'd1;
	localparam logic [7:0] VT_FLOAT   = 8'd2;
	localparam logic [7:0] VT_STRING  = 8'd3;

	// file magic "BINI"
	localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h49, 8'h4E, 8'h49};

	// header layout
	localparam int MIN_LEN       = 12;
	localparam int HDR_MAGIC_END = 4;
	localparam int HDR_OFS_FIRST = 8;
	localparam int HDR_OFS_LAST  = 11;

	// record sizes and the index of each record's last byte
	localparam int SEC_BYTES = 4;
	localparam int ENT_BYTES = 3;
	localparam int VAL_BYTES = 5;
	localparam logic [2:0] SEC_LAST = 3'd3;
	localparam logic [2:0] ENT_LAST = 3'd2;
	localparam logic [2:0] VAL_LAST = 3'd4;

	// bound compares run one bit above the 32-bit strings offset
	localparam int CMP_W = 33;
	typedef logic [CMP_W-1:0] cmp_t;

	// walk state touched by the record bound checks
	typedef struct packed {
		phase_t      phase;
		logic [15:0] entries_left;
		logic [7:0]  values_left;
	} walk_t;

endpackage

[rtl/binary_ini_record_parser_core.sv]
`timescale 1ns / 1ps
// binary ini record parser: header check and record tokenizer, one byte per transfer
// depends on bini_pkg
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  in       | input     | in_valid/in_stall  | data_byte, first_byte
//  out      | output    | out_valid/out_stall| token_kind, token_payload, token_count
//  cfg      | input     | cfg_wr_en          | cfg_wr_data (file_length)
//
// one byte is taken every cycle while in_stall is low; a token leaves through the input register,
// then the single-pass parse step into the result register
// arst_n clears the file length to zero and the parser to the header phase
// out_stall holds the result register; input keeps flowing until the input register
// also holds a byte, then in_stall rises
module binary_ini_record_parser_core #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [LENGTH_BITS-1:0] cfg_wr_data,
	// byte input
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	// token output
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             token_kind,
	output logic [31:0]            token_payload,
	output logic [15:0]            token_count
);

	// decide the next record at a position: value, entry and section bounds
	function automatic bini_pkg::walk_t resolve(bini_pkg::walk_t w, bini_pkg::cmp_t p,
			bini_pkg::cmp_t fl, bini_pkg::cmp_t so);
		bini_pkg::walk_t r;
		r = w;
		if (r.phase == bini_pkg::PH_VALUE &&
				(r.values_left == 8'd0 || p + bini_pkg::cmp_t'(bini_pkg::VAL_BYTES) > fl)) begin
			r.values_left = 8'd0;
			if (r.entries_left != 16'd0)
				r.entries_left = r.entries_left - 16'd1;
			r.phase = bini_pkg::PH_ENTRY;
		end
		if (r.phase == bini_pkg::PH_ENTRY) begin
			if (r.entries_left == 16'd0) begin
				r.phase = bini_pkg::PH_SECTION;
			end else if (p + bini_pkg::cmp_t'(bini_pkg::ENT_BYTES) > so) begin
				r.phase = bini_pkg::PH_DONE;
				r.entries_left = 16'd0;
			end
		end
		if (r.phase == bini_pkg::PH_SECTION && p + bini_pkg::cmp_t'(bini_pkg::SEC_BYTES) > so)
			r.phase = bini_pkg::PH_DONE;
		return r;
	endfunction

	// registers
	logic                   file_length_q;
	logic [LENGTH_BITS-1:0] flen_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   first_s1;
	bini_pkg::phase_t       phase_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [31:0]            strings_ofs_q;
	logic [31:0]            field_q;
	logic [2:0]             rec_cnt_q;
	logic [15:0]            entries_q;
	logic [7:0]             values_q;
	logic [7:0]             vtype_q;
	logic                   out_valid_q;
	logic [2:0]             kind_q;
	logic [31:0]            payload_q;
	logic [15:0]            count_q;

	// working view and next values
	bini_pkg::phase_t       ph_c;
	logic [LENGTH_BITS-1:0] pos_c;
	logic [31:0]            so_c;
	logic [31:0]            fs_c;
	logic [2:0]             k_c;
	logic [15:0]            el_c;
	logic [7:0]             vl_c;
	logic [7:0]             vt_c;
	logic [1:0]             lane_c;
	logic [31:0]            fs_or_c;
	logic [31:0]            hdr_fs_c;
	logic                   hdr_early_fail_c;
	logic                   hdr_ofs_fail_c;
	logic                   advance;
	logic                   step;

	bini_pkg::walk_t        walk;
	logic                   do_resolve;
	logic [LENGTH_BITS-1:0] n_pos;
	logic [31:0]            n_so;
	logic [31:0]            n_fs;
	logic [2:0]             n_k;
	logic [7:0]             n_vt;

	logic                   tok_v;
	logic [2:0]             tok_kind;
	logic [31:0]            tok_payload;
	logic [15:0]            tok_count;

	// handshake: the result register frees up when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// file length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= '0;
			file_length_q <= 1'b0;
		end else if (cfg_wr_en) begin
			flen_q <= cfg_wr_data;
			file_length_q <= 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	// state seen by this byte, cleared when it starts a new file
	always_comb begin
		ph_c  = first_s1 ? bini_pkg::PH_HEADER : phase_q;
		pos_c = first_s1 ? '0 : pos_q;
		so_c  = first_s1 ? 32'd0 : strings_ofs_q;
		fs_c  = first_s1 ? 32'd0 : field_q;
		k_c   = first_s1 ? 3'd0 : rec_cnt_q;
		el_c  = first_s1 ? 16'd0 : entries_q;
		vl_c  = first_s1 ? 8'd0 : values_q;
		vt_c  = first_s1 ? 8'd0 : vtype_q;

		// byte lane of the field being assembled
		case (ph_c)
			bini_pkg::PH_HEADER: lane_c = pos_c[1:0];
			bini_pkg::PH_VALUE:  lane_c = 2'(k_c - 3'd1);
			default:             lane_c = k_c[1:0];
		endcase
		fs_or_c = fs_c | (32'(byte_s1) << {lane_c, 3'b000});

		// header checks
		hdr_fs_c = (pos_c >= LENGTH_BITS'(bini_pkg::HDR_OFS_FIRST) &&
			pos_c <= LENGTH_BITS'(bini_pkg::HDR_OFS_LAST)) ? fs_or_c : fs_c;
		hdr_early_fail_c = (pos_c == '0 &&
				bini_pkg::cmp_t'(flen_q) < bini_pkg::cmp_t'(bini_pkg::MIN_LEN)) ||
			(pos_c < LENGTH_BITS'(bini_pkg::HDR_MAGIC_END) &&
				byte_s1 != bini_pkg::MAGIC[pos_c[1:0]]);
		hdr_ofs_fail_c = pos_c >= LENGTH_BITS'(bini_pkg::HDR_OFS_LAST) &&
			(bini_pkg::cmp_t'(hdr_fs_c) < bini_pkg::cmp_t'(bini_pkg::MIN_LEN) ||
				bini_pkg::cmp_t'(hdr_fs_c) > bini_pkg::cmp_t'(flen_q));
	end

	// next state
	always_comb begin
		walk.phase        = ph_c;
		walk.entries_left = el_c;
		walk.values_left  = vl_c;
		do_resolve = 1'b0;
		n_pos = pos_c;
		n_so  = so_c;
		n_fs  = fs_c;
		n_k   = k_c;
		n_vt  = vt_c;
		case (ph_c)
			bini_pkg::PH_HEADER: begin
				if (hdr_early_fail_c) begin
					walk = '{bini_pkg::PH_DONE, 16'd0, 8'd0};
				end else begin
					n_fs  = hdr_fs_c;
					n_pos = pos_c + LENGTH_BITS'(1);
					if (pos_c >= LENGTH_BITS'(bini_pkg::HDR_OFS_LAST)) begin
						n_so = hdr_fs_c;
						n_fs = 32'd0;
						if (hdr_ofs_fail_c) begin
							walk = '{bini_pkg::PH_DONE, 16'd0, 8'd0};
						end else begin
							walk.phase = bini_pkg::PH_SECTION;
							do_resolve = 1'b1;
						end
					end
				end
			end
			bini_pkg::PH_SECTION: begin
				n_pos = pos_c + LENGTH_BITS'(1);
				if (k_c >= bini_pkg::SEC_LAST) begin
					walk.entries_left = fs_or_c[31:16];
					walk.phase = bini_pkg::PH_ENTRY;
					n_fs = 32'd0;
					n_k  = 3'd0;
					do_resolve = 1'b1;
				end else begin
					n_fs = fs_or_c;
					n_k  = k_c + 3'd1;
				end
			end
			bini_pkg::PH_ENTRY: begin
				n_pos = pos_c + LENGTH_BITS'(1);
				if (k_c >= bini_pkg::ENT_LAST) begin
					walk.values_left = byte_s1;
					walk.phase = bini_pkg::PH_VALUE;
					n_fs = 32'd0;
					n_k  = 3'd0;
					do_resolve = 1'b1;
				end else begin
					n_fs = fs_or_c;
					n_k  = k_c + 3'd1;
				end
			end
			bini_pkg::PH_VALUE: begin
				n_pos = pos_c + LENGTH_BITS'(1);
				if (k_c == 3'd0) begin
					n_vt = byte_s1;
					n_fs = 32'd0;
					n_k  = 3'd1;
				end else if (k_c >= bini_pkg::VAL_LAST) begin
					if (vl_c != 8'd0)
						walk.values_left = vl_c - 8'd1;
					n_fs = 32'd0;
					n_k  = 3'd0;
					do_resolve = 1'b1;
				end else begin
					n_fs = fs_or_c;
					n_k  = k_c + 3'd1;
				end
			end
			default: begin
				// parse stopped: bytes are dropped
			end
		endcase
		if (do_resolve)
			walk = resolve(walk, bini_pkg::cmp_t'(n_pos), bini_pkg::cmp_t'(flen_q),
				bini_pkg::cmp_t'(n_so));
	end

	// token of this byte
	always_comb begin
		tok_v       = 1'b0;
		tok_kind    = bini_pkg::TOK_ERROR;
		tok_payload = 32'd0;
		tok_count   = 16'd0;
		case (ph_c)
			bini_pkg::PH_HEADER: begin
				tok_v = hdr_early_fail_c || hdr_ofs_fail_c;
			end
			bini_pkg::PH_SECTION: begin
				if (k_c >= bini_pkg::SEC_LAST) begin
					tok_v       = 1'b1;
					tok_kind    = bini_pkg::TOK_SECTION;
					tok_payload = {16'd0, fs_or_c[15:0]};
					tok_count   = fs_or_c[31:16];
				end
			end
			bini_pkg::PH_ENTRY: begin
				if (k_c >= bini_pkg::ENT_LAST) begin
					tok_v       = 1'b1;
					tok_kind    = bini_pkg::TOK_KEY;
					tok_payload = {16'd0, fs_c[15:0]};
					tok_count   = {8'd0, byte_s1};
				end
			end
			bini_pkg::PH_VALUE: begin
				if (k_c >= bini_pkg::VAL_LAST) begin
					tok_payload = fs_or_c;
					case (vt_c)
						bini_pkg::VT_INTEGER: begin
							tok_v    = 1'b1;
							tok_kind = bini_pkg::TOK_INTEGER;
						end
						bini_pkg::VT_FLOAT: begin
							tok_v    = 1'b1;
							tok_kind = bini_pkg::TOK_FLOAT;
						end
						bini_pkg::VT_STRING: begin
							tok_v    = 1'b1;
							tok_kind = bini_pkg::TOK_STRING;
						end
						default: begin
							// unknown type: consumed silently
							tok_v = 1'b0;
						end
					endcase
				end
			end
			default: begin
				tok_v = 1'b0;
			end
		endcase
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= bini_pkg::PH_HEADER;
			pos_q         <= '0;
			strings_ofs_q <= 32'd0;
			field_q       <= 32'd0;
			rec_cnt_q     <= 3'd0;
			entries_q     <= 16'd0;
			values_q      <= 8'd0;
			vtype_q       <= 8'd0;
		end else if (step) begin
			phase_q       <= walk.phase;
			pos_q         <= n_pos;
			strings_ofs_q <= n_so;
			field_q       <= n_fs;
			rec_cnt_q     <= n_k;
			entries_q     <= walk.entries_left;
			values_q      <= walk.values_left;
			vtype_q       <= n_vt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && tok_v;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q    <= tok_kind;
			payload_q <= tok_payload;
			count_q   <= tok_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign token_kind    = kind_q;
	assign token_payload = payload_q;
	assign token_count   = count_q;

	// a stopped parse stays stopped until a first byte comes through
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bini_pkg::PH_DONE && !(step && first_s1))
			|=> (phase_q == bini_pkg::PH_DONE && $stable(pos_q)))
		else $error("parser left the done phase without a new file");

	// an error token always stops the parse
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(step && tok_v && tok_kind == bini_pkg::TOK_ERROR) |=> phase_q == bini_pkg::PH_DONE)
		else $error("error token without a stop");

	// a stopped parse has no pending entries or values
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bini_pkg::PH_DONE |-> (entries_q == 16'd0 && values_q == 8'd0))
		else $error("counts left over in the done phase");

	// no record is longer than a value
	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_cnt_q > bini_pkg::VAL_LAST))
		else $error("record byte count out of range");

	// a token only leaves with a byte that was parsed
	a_tok_source: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !valid_s1) |=> !out_valid_q)
		else $error("token without a parsed byte");

	// the file length register is loaded only by a write
	a_cfg_load: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr_en |=> ($stable(flen_q) && $stable(file_length_q)))
		else $error("file length changed without a write");

endmodule

[verif/bini_token_checker.sv]
`timescale 1ns / 1ps
// token checker for binary_ini_record_parser_core: tracks the parse of every byte transfer,
// queues the tokens it must produce and compares each output transfer against them
// depends on bini_pkg
module bini_token_checker #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [LENGTH_BITS-1:0] cfg_wr_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   first_byte,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [2:0]             token_kind,
	input  logic [31:0]            token_payload,
	input  logic [15:0]            token_count,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] payload;
		logic [15:0] count;
	} token_t;

	// parse state as the file walk sees it
	logic [LENGTH_BITS-1:0] file_len;
	logic [LENGTH_BITS-1:0] byte_pos;
	bini_pkg::phase_t       ph;
	logic [31:0]            str_ofs;
	logic [31:0]            shift_acc;
	logic [2:0]             rec_cnt;
	logic [15:0]            entries_left;
	logic [7:0]             values_left;
	logic [7:0]             vtype;

	token_t tokens_due[$];
	int     shown;

	function automatic void clear_walk();
		byte_pos     = '0;
		ph           = bini_pkg::PH_HEADER;
		str_ofs      = '0;
		shift_acc    = '0;
		rec_cnt      = '0;
		entries_left = '0;
		values_left  = '0;
		vtype        = '0;
	endfunction

	function automatic void abort_parse(output token_t tok);
		ph           = bini_pkg::PH_DONE;
		entries_left = '0;
		values_left  = '0;
		tok          = '{bini_pkg::TOK_ERROR, 32'd0, 16'd0};
	endfunction

	// pick the next record kind at the current position, applying the bound rules
	function automatic void settle_walk();
		bit again;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			if (ph == bini_pkg::PH_VALUE) begin
				if (values_left == 0 ||
						64'(byte_pos) + bini_pkg::VAL_BYTES > 64'(file_len)) begin
					values_left = '0;
					if (entries_left > 0)
						entries_left--;
					ph    = bini_pkg::PH_ENTRY;
					again = 1'b1;
				end
			end else if (ph == bini_pkg::PH_ENTRY) begin
				if (entries_left == 0) begin
					ph    = bini_pkg::PH_SECTION;
					again = 1'b1;
				end else if (64'(byte_pos) + bini_pkg::ENT_BYTES > 64'(str_ofs)) begin
					ph           = bini_pkg::PH_DONE;
					entries_left = '0;
				end
			end else if (ph == bini_pkg::PH_SECTION &&
					64'(byte_pos) + bini_pkg::SEC_BYTES > 64'(str_ofs)) begin
				ph = bini_pkg::PH_DONE;
			end
		end
	endfunction

	// advance the parse by one byte; returns 1 when a token is due
	function automatic bit parse_byte(input logic [7:0] b, input logic restart,
			output token_t tok);
		logic [LENGTH_BITS-1:0] p;
		logic [2:0]             k;
		bit                     hit;
		hit = 1'b0;
		tok = '0;
		if (restart)
			clear_walk();
		if (ph == bini_pkg::PH_DONE)
			return 1'b0;
		p = byte_pos;
		k = rec_cnt;

		// file header: length, magic, strings offset
		if (ph == bini_pkg::PH_HEADER) begin
			if (p == 0 && file_len < bini_pkg::MIN_LEN) begin
				abort_parse(tok);
				return 1'b1;
			end
			if (p < bini_pkg::HDR_MAGIC_END && b != bini_pkg::MAGIC[p[1:0]]) begin
				abort_parse(tok);
				return 1'b1;
			end
			if (p >= bini_pkg::HDR_OFS_FIRST && p <= bini_pkg::HDR_OFS_LAST)
				shift_acc |= 32'(b) << (8 * p[1:0]);
			byte_pos = p + 1'b1;
			if (p >= bini_pkg::HDR_OFS_LAST) begin
				str_ofs   = shift_acc;
				shift_acc = '0;
				if (str_ofs < bini_pkg::MIN_LEN || str_ofs > file_len) begin
					abort_parse(tok);
					return 1'b1;
				end
				ph = bini_pkg::PH_SECTION;
				settle_walk();
			end
			return 1'b0;
		end

		byte_pos = p + 1'b1;
		case (ph)
			// section header: name offset, entry count
			bini_pkg::PH_SECTION: begin
				shift_acc |= 32'(b) << (8 * k[1:0]);
				if (k >= bini_pkg::SEC_LAST) begin
					tok          = '{bini_pkg::TOK_SECTION, {16'd0, shift_acc[15:0]},
						shift_acc[31:16]};
					hit          = 1'b1;
					entries_left = shift_acc[31:16];
					shift_acc    = '0;
					rec_cnt      = '0;
					ph           = bini_pkg::PH_ENTRY;
					settle_walk();
				end else begin
					rec_cnt = k + 1'b1;
				end
			end
			// entry header: key offset, value count
			bini_pkg::PH_ENTRY: begin
				if (k >= bini_pkg::ENT_LAST) begin
					tok         = '{bini_pkg::TOK_KEY, {16'd0, shift_acc[15:0]}, {8'd0, b}};
					hit         = 1'b1;
					values_left = b;
					shift_acc   = '0;
					rec_cnt     = '0;
					ph          = bini_pkg::PH_VALUE;
					settle_walk();
				end else begin
					shift_acc |= 32'(b) << (8 * k[1:0]);
					rec_cnt = k + 1'b1;
				end
			end
			// typed value: type byte then 32 bits
			default: begin
				if (k == 0) begin
					vtype     = b;
					shift_acc = '0;
					rec_cnt   = 3'd1;
				end else begin
					shift_acc |= 32'(b) << (8 * (k - 1));
					if (k >= bini_pkg::VAL_LAST) begin
						hit = 1'b1;
						case (vtype)
							bini_pkg::VT_INTEGER: tok = '{bini_pkg::TOK_INTEGER, shift_acc, 16'd0};
							bini_pkg::VT_FLOAT:   tok = '{bini_pkg::TOK_FLOAT, shift_acc, 16'd0};
							bini_pkg::VT_STRING:  tok = '{bini_pkg::TOK_STRING, shift_acc, 16'd0};
							default:              hit = 1'b0;
						endcase
						if (values_left > 0)
							values_left--;
						shift_acc = '0;
						rec_cnt   = '0;
						settle_walk();
					end else begin
						rec_cnt = k + 1'b1;
					end
				end
			end
		endcase
		return hit;
	endfunction

	// follow config writes, byte transfers and token transfers
	always @(posedge clk or negedge arst_n) begin : watch
		token_t want;
		token_t got;
		if (!arst_n) begin
			file_len = '0;
			clear_walk();
			tokens_due.delete();
			errors  = 0;
			pending = 0;
			shown   = 0;
		end else begin
			if (cfg_wr_en)
				file_len = cfg_wr_data;
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, first_byte, want))
					tokens_due.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{token_kind, token_payload, token_count};
				if (tokens_due.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("checker: token with none due: kind %0d payload %h count %0d",
							got.kind, got.payload, got.count);
					end
				end else begin
					want = tokens_due.pop_front();
					if (got.kind !== want.kind || got.payload !== want.payload ||
							got.count !== want.count) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("checker: token mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
								want.kind, want.payload, want.count,
								got.kind, got.payload, got.count);
						end
					end
				end
			end
			pending = tokens_due.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// testbench top for binary_ini_record_parser_core: streams directed and random ini files
// under varying idle and stall pressure and reports the verdict
// depends on bini_pkg, binary_ini_record_parser_core and bini_token_checker
module tb;

	localparam int LEN_W        = 24;
	localparam int RANDOM_ITEMS = 450;

	logic              clk         = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en   = 1'b0;
	logic [LEN_W-1:0]  cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte   = '0;
	logic              first_byte  = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [2:0]        token_kind;
	logic [31:0]       token_payload;
	logic [15:0]       token_count;
	int                chk_errors;
	int                chk_pending;

	// file being streamed and traffic shaping
	logic [7:0] file_image[$];
	int         restart_at;
	int         rec_end;
	int         items_sent = 0;
	int         idle_pct   = 0;
	int         stall_pct  = 0;

	binary_ini_record_parser_core #(.LENGTH_BITS(LEN_W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .first_byte(first_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_payload(token_payload), .token_count(token_count)
	);

	bini_token_checker #(.LENGTH_BITS(LEN_W)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .first_byte(first_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_payload(token_payload), .token_count(token_count),
		.errors(chk_errors), .pending(chk_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	task automatic put_le(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_image.push_back(v[8*i +: 8]);
	endtask

	// one byte transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic f);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		first_byte <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold the sender until every due token is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (chk_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// load the length register while idle, then stream the image
	task automatic run_file(input logic [LEN_W-1:0] len);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		foreach (file_image[i])
			send_byte(file_image[i], i == 0 || i == restart_at);
	endtask

	// mostly well-formed file with random content, sometimes bent or broken
	task automatic build_file(output logic [LEN_W-1:0] len);
		int          n_sec;
		int          n_ent;
		int          n_val;
		int          roll;
		int          total;
		logic [15:0] ent_field;
		logic [7:0]  val_field;
		logic [31:0] ofs;
		file_image.delete();
		restart_at = -1;
		for (int i = 0; i < bini_pkg::HDR_MAGIC_END; i++)
			file_image.push_back(bini_pkg::MAGIC[i]);
		put_le($urandom, 4);
		put_le(32'd0, 4);

		// sections, entries and values; counts sometimes overstate what follows
		n_sec = $urandom_range(0, 3);
		for (int s = 0; s < n_sec; s++) begin
			n_ent = $urandom_range(0, 3);
			roll = $urandom_range(0, 9);
			ent_field = (roll == 0) ? 16'($urandom) : (roll == 1) ? 16'(n_ent + 1) : 16'(n_ent);
			put_le({ent_field, 16'($urandom)}, bini_pkg::SEC_BYTES);
			for (int e = 0; e < n_ent; e++) begin
				n_val = $urandom_range(0, 4);
				roll = $urandom_range(0, 9);
				val_field = (roll == 0) ? 8'($urandom) : (roll == 1) ? 8'(n_val + 1) : 8'(n_val);
				put_le({8'd0, val_field, 16'($urandom)}, bini_pkg::ENT_BYTES);
				for (int v = 0; v < n_val; v++) begin
					file_image.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom)
						: 8'($urandom_range(bini_pkg::VT_INTEGER, bini_pkg::VT_STRING)));
					put_le($urandom, 4);
				end
			end
		end
		rec_end = file_image.size();
		ofs = 32'(rec_end);

		// string table
		repeat ($urandom_range(0, 6))
			file_image.push_back(8'($urandom));
		total = file_image.size();
		len = LEN_W'(total);

		// bounds: early strings offset, short length, bad offsets, largest length
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
		end else if (roll < 65) begin
			ofs = $urandom_range(bini_pkg::MIN_LEN, rec_end);
		end else if (roll < 75) begin
			ofs = $urandom_range(bini_pkg::MIN_LEN, rec_end);
			len = LEN_W'($urandom_range(ofs, total));
		end else if (roll < 80) begin
			ofs = total + $urandom_range(1, 300);
		end else if (roll < 83) begin
			ofs = $urandom;
		end else if (roll < 87) begin
			ofs = $urandom_range(0, bini_pkg::MIN_LEN - 1);
		end else if (roll < 93) begin
			len = '1;
		end else begin
			len = LEN_W'($urandom_range(0, bini_pkg::MIN_LEN - 1));
		end
		for (int i = 0; i < 4; i++)
			file_image[bini_pkg::HDR_OFS_FIRST + i] = ofs[8*i +: 8];

		// damage: a stray byte, a restart in mid-file, a cut-off file
		roll = $urandom_range(0, 99);
		if (roll < 5)
			file_image[$urandom_range(0, total - 1)] = 8'($urandom);
		else if (roll < 10)
			restart_at = $urandom_range(1, total - 1);
		else if (roll < 18)
			file_image = file_image[0:$urandom_range(0, total - 1)];
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] len;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short files, bad magic, smallest valid file
		restart_at = -1;
		file_image = '{8'h42, 8'h49};
		run_file('0);
		file_image = '{8'h42};
		run_file(LEN_W'(bini_pkg::MIN_LEN - 1));
		file_image = '{8'h42, 8'h49, 8'h4E, 8'h00};
		run_file(LEN_W'(20));
		file_image = '{8'h42, 8'h49, 8'h4E, 8'h49, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h0C, 8'h00, 8'h00, 8'h00, 8'hA5};
		run_file(LEN_W'(bini_pkg::MIN_LEN));

		// random files, idle and stall pressure stepping through their phases
		while (items_sent < RANDOM_ITEMS) begin
			case (items_sent * 4 / RANDOM_ITEMS)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
			endcase
			build_file(len);
			run_file(len);
			items_sent += (file_image.size() < rec_end) ? file_image.size() : rec_end;
		end

		settle();
		@(negedge clk);
		if (chk_errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
